// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define HPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/hpq_pkg.sv =====
package hpq_pkg;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic ORDER_MIN = 1'b1;

    // true when a belongs above b in the selected order
    function automatic logic above(input logic order, input logic signed [31:0] a,
                                   input logic signed [31:0] b);
        logic r;
        if (order == ORDER_MIN)
            r = (a < b);
        else
            r = (a > b);
        return r;
    endfunction

endpackage

// ===== hdl/hpq_ram.sv =====
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/binary_heap_priority_queue.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------
// command   | start, busy (accept: start & !busy) | func, value
// result    | done (one-cycle strobe)    | top_value, status, count
// config    | cfg_valid, cfg_ready       | heap_order
//
// Insert: UP_CHK, UP_CMP per level climbed; ends in UP_CHK at the root, else UP_CMP.
// Extract: DN_TOP, DN_LAST, then DN_CHK, DN_LEFT, DN_DEC per level; ends in DN_CHK at
// a leaf or DN_DEC if no child wins, in DN_TOP if it empties the heap. Empty and full:
// busy stays low and the result strobe follows in the next cycle; else it comes as busy falls.
// Reset clears the count and selects min order; memory contents stay as they are.
// The result strobe cannot be held off; start is ignored while busy is high.
module binary_heap_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] top_value,
    output logic [1:0]         status,
    output logic [7:0]         count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               heap_order
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_CHK  = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_DN_TOP  = 8'b0000_1000,
        S_DN_LAST = 8'b0001_0000,
        S_DN_CHK  = 8'b0010_0000,
        S_DN_LEFT = 8'b0100_0000,
        S_DN_DEC  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [31:0] lv_reg, lv_next;
    logic signed [31:0] top_reg, top_next;
    logic [1:0]         status_reg, status_next;
    logic               done_reg, done_next;
    logic               order_reg;

    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;
    logic               re;
    logic [AW-1:0]      raddr;
    logic signed [31:0] rdata;

    logic [IW-1:0]      pos_ext, cnt_ext, left, right;
    logic [AW-1:0]      parent;
    logic               l_ok, r_ok, take_l, take_r;
    logic signed [31:0] bv_l;
    logic [CW+7:0]      cnt_wide;

    hpq_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign pos_ext = {2'b00, pos_reg};
    assign cnt_ext = {{(IW - CW){1'b0}}, cnt_reg};
    assign left    = (pos_ext << 1) + IW'(1);
    assign right   = left + IW'(1);
    assign parent  = (pos_reg - AW'(1)) >> 1;
    assign l_ok    = left < cnt_ext;
    assign r_ok    = right < cnt_ext;
    assign take_l  = hpq_pkg::above(order_reg, lv_reg, v_reg);
    assign bv_l    = take_l ? lv_reg : v_reg;
    assign take_r  = r_ok && hpq_pkg::above(order_reg, rdata, bv_l);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        v_next      = v_reg;
        lv_next     = lv_reg;
        top_next    = top_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = v_reg;
        re          = 1'b0;
        raddr       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    top_next    = '0;
                    status_next = hpq_pkg::ST_OK;
                    if (func == hpq_pkg::FUNC_INSERT)
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            status_next = hpq_pkg::ST_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            v_next     = value;
                            pos_next   = cnt_reg[AW-1:0];
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = hpq_pkg::ST_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            // fetch the root
                            re         = 1'b1;
                            raddr      = '0;
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = S_DN_TOP;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                if (hpq_pkg::above(order_reg, v_reg, rdata))
                begin
                    // move the parent down into the hole
                    wdata      = rdata;
                    pos_next   = parent;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DN_TOP:
            begin
                top_next = rdata;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = cnt_reg[AW-1:0];
                    state_next = S_DN_LAST;
                end
            end
            S_DN_LAST:
            begin
                v_next     = rdata;
                pos_next   = '0;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (!l_ok)
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = left[AW-1:0];
                    state_next = S_DN_LEFT;
                end
            end
            S_DN_LEFT:
            begin
                lv_next = rdata;
                if (r_ok)
                begin
                    re    = 1'b1;
                    raddr = right[AW-1:0];
                end
                state_next = S_DN_DEC;
            end
            S_DN_DEC:
            begin
                we = 1'b1;
                if (take_r)
                begin
                    wdata      = rdata;
                    pos_next   = right[AW-1:0];
                    state_next = S_DN_CHK;
                end
                else if (take_l)
                begin
                    wdata      = lv_reg;
                    pos_next   = left[AW-1:0];
                    state_next = S_DN_CHK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            order_reg <= hpq_pkg::ORDER_MIN;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= heap_order;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        v_reg      <= v_next;
        lv_reg     <= lv_next;
        top_reg    <= top_next;
        status_reg <= status_next;
    end

    assign cnt_wide  = {8'b0, cnt_reg};
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign top_value = top_reg;
    assign status    = status_reg;
    assign count     = cnt_wide[7:0];

endmodule

// ===== hdl/hpq_checker.sv =====
`include "assert_macros.svh"

module hpq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               func,
    input logic signed [31:0] value,
    input logic               done,
    input logic signed [31:0] top_value,
    input logic [1:0]         status,
    input logic [7:0]         count,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               heap_order
);

    // an accepted item is either answered at once or keeps the block busy
    `HPQ_ASSERT(a_accept_progress, start && !busy |=> done || busy, "accepted item went nowhere")

    // leaving the busy phase always delivers the result
    `HPQ_ASSERT(a_fall_done, $fell(busy) |-> done, "busy dropped without a result")

    // a failed extract only happens on an empty heap and returns zero
    `HPQ_ASSERT(a_empty_result, done && status == hpq_pkg::ST_EMPTY |-> count == 8'd0 && top_value == 32'sd0, "bad empty result")

    // a rejected insert returns zero
    `HPQ_ASSERT(a_full_result, done && status == hpq_pkg::ST_FULL |-> top_value == 32'sd0, "bad full result")

    // reset leaves the block idle and silent
    `HPQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !done, "not idle after reset")

endmodule

bind binary_heap_priority_queue hpq_checker u_hpq_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int HEAP_DEPTH = 128;
    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_PAUSE = 40;
    localparam logic ORDER_MAX = ~hpq_pkg::ORDER_MIN;

    typedef struct {
        logic signed [31:0] top;
        logic [1:0]         status;
        logic [7:0]         count;
    } heap_result_t;

    class heap_scoreboard;
        logic signed [31:0] entries[HEAP_DEPTH];
        int unsigned        held;
        logic               order;
        heap_result_t       awaited[$];
        int                 failures;

        function new();
            held = 0;
            order = hpq_pkg::ORDER_MIN;
            failures = 0;
        endfunction

        function bit ranks_higher(logic signed [31:0] a, logic signed [31:0] b);
            return (order == hpq_pkg::ORDER_MIN) ? (a < b) : (a > b);
        endfunction

        function void swap_entries(int unsigned x, int unsigned y);
            logic signed [31:0] t;
            t = entries[x];
            entries[x] = entries[y];
            entries[y] = t;
        endfunction

        function void note_command(logic op, logic signed [31:0] v);
            heap_result_t r;
            int unsigned pos;
            int unsigned parent;
            int unsigned best;
            int unsigned lc;
            r.top = '0;
            r.status = hpq_pkg::ST_OK;
            if (op == hpq_pkg::FUNC_INSERT)
            begin
                if (held >= HEAP_DEPTH)
                begin
                    r.status = hpq_pkg::ST_FULL;
                end
                else
                begin
                    entries[held] = v;
                    pos = held;
                    held++;
                    while (pos > 0)
                    begin
                        parent = (pos - 1) / 2;
                        if (!ranks_higher(entries[pos], entries[parent]))
                            break;
                        swap_entries(pos, parent);
                        pos = parent;
                    end
                end
            end
            else
            begin
                if (held == 0)
                begin
                    r.status = hpq_pkg::ST_EMPTY;
                end
                else
                begin
                    r.top = entries[0];
                    held--;
                    entries[0] = entries[held];
                    pos = 0;
                    forever
                    begin
                        best = pos;
                        lc = 2 * pos + 1;
                        if (lc < held && ranks_higher(entries[lc], entries[best]))
                            best = lc;
                        if (lc + 1 < held && ranks_higher(entries[lc + 1], entries[best]))
                            best = lc + 1;
                        if (best == pos)
                            break;
                        swap_entries(pos, best);
                        pos = best;
                    end
                end
            end
            r.count = held[7:0];
            awaited.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] top, logic [1:0] st, logic [7:0] cnt);
            heap_result_t e;
            if (awaited.size() == 0)
            begin
                if (failures < 10)
                    $display("unexpected result: top %0d status %0d count %0d", top, st, cnt);
                failures++;
            end
            else
            begin
                e = awaited.pop_front();
                if (top !== e.top || st !== e.status || cnt !== e.count)
                begin
                    if (failures < 10)
                        $display({"mismatch: expected top %0d status %0d count %0d, ",
                                  "got top %0d status %0d count %0d"},
                                 e.top, e.status, e.count, top, st, cnt);
                    failures++;
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               func;
    logic signed [31:0] value;
    logic               done;
    logic signed [31:0] top_value;
    logic [1:0]         status;
    logic [7:0]         count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               heap_order;

    heap_scoreboard sb = new();
    int             items_sent;
    bit             steady;
    int             cycle_count;

    binary_heap_priority_queue #(.CAPACITY(HEAP_DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .value      (value),
        .done       (done),
        .top_value  (top_value),
        .status     (status),
        .count      (count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .heap_order (heap_order)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Note config writes and accepted items before checking, so a write taken with an item applies to it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                sb.order = heap_order;
            if (start === 1'b1 && busy === 1'b0)
                sb.note_command(func, value);
            if (done === 1'b1)
                sb.check_result(top_value, status, count);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("binary_heap_priority_queue regression: fail");
        $finish;
    end

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(3))
                    0: v = 32'sh7FFFFFFF;
                    1: v = 32'sh80000000;
                    2: v = 32'sh0;
                    default: v = -32'sd1;
                endcase
            end
            1, 2: v = $signed($urandom_range(15)) - 32'sd8;
            default: v = $signed($urandom);
        endcase
        return v;
    endfunction

    // Called just after a falling edge; returns just after a falling edge, once the item has been accepted.
    task automatic send_item(input logic op, input logic signed [31:0] v);
        if (!steady && $urandom_range(99) < 33)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
        start = 1'b1;
        func = op;
        value = v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input int insert_pct);
        send_item(($urandom_range(99) < insert_pct) ? hpq_pkg::FUNC_INSERT
                                                    : hpq_pkg::FUNC_EXTRACT,
                  pick_value());
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_order(input logic ord);
        wait_drained();
        cfg_valid = 1'b1;
        heap_order = ord;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int phase;
        rst_n = 1'b0;
        start = 1'b0;
        func = hpq_pkg::FUNC_INSERT;
        value = '0;
        cfg_valid = 1'b0;
        heap_order = hpq_pkg::ORDER_MIN;
        items_sent = 0;
        steady = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // extremes, duplicates, empty extract, order flip with entries held
        send_item(hpq_pkg::FUNC_EXTRACT, 32'sh0);
        send_item(hpq_pkg::FUNC_INSERT, 32'sh7FFFFFFF);
        send_item(hpq_pkg::FUNC_INSERT, 32'sh80000000);
        send_item(hpq_pkg::FUNC_INSERT, -32'sd1);
        send_item(hpq_pkg::FUNC_INSERT, 32'sh0);
        send_item(hpq_pkg::FUNC_INSERT, 32'sd5);
        send_item(hpq_pkg::FUNC_INSERT, 32'sd5);
        repeat (3) send_item(hpq_pkg::FUNC_EXTRACT, 32'sh0);
        write_order(ORDER_MAX);
        send_item(hpq_pkg::FUNC_INSERT, 32'sd1);
        repeat (2) send_item(hpq_pkg::FUNC_EXTRACT, 32'sh0);
        write_order(hpq_pkg::ORDER_MIN);
        repeat (4) send_item(hpq_pkg::FUNC_EXTRACT, 32'sh0);

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (phase < 2)
                write_order(phase == 0 ? ORDER_MAX : hpq_pkg::ORDER_MIN);
            else
                write_order(1'($urandom_range(1)));
            steady = (phase == 1);
            case (phase % 3)
                0: repeat (150) send_random(50);
                1:
                begin
                    // fill to capacity, then push past it
                    while (sb.held < HEAP_DEPTH)
                        send_random(90);
                    repeat (4) send_item(hpq_pkg::FUNC_INSERT, pick_value());
                end
                default:
                begin
                    while (sb.held > 0)
                        send_random(15);
                    repeat (3) send_item(hpq_pkg::FUNC_EXTRACT, pick_value());
                end
            endcase
            phase++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_PAUSE) @(negedge clk);
        if (sb.awaited.size() != 0)
        begin
            $display("%0d results never arrived", sb.awaited.size());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("binary_heap_priority_queue regression: pass");
        else
            $display("binary_heap_priority_queue regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hpq_pkg.sv
hdl/hpq_ram.sv
hdl/binary_heap_priority_queue.sv
hdl/hpq_checker.sv
tb/sv/tb.sv
